### rtl/thi_pkg.sv
// Package for the triple EMA and Hull average block: sizes, register indexes,
// and the request and response types of the serial divider.
// No dependencies.
package thi_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int MAX_PERIOD    = 64;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    localparam int PRICE_W = 32;
    localparam int VALUE_W = 48;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;
    localparam int DIVISOR_W = 11;

    typedef enum logic [CFG_AW-1:0] {
        CFG_TEMA_PERIOD     = 2'd0,
        CFG_EMA_WEIGHT      = 2'd1,
        CFG_SEED_RECIPROCAL = 2'd2,
        CFG_HULL_ROOT       = 2'd3
    } thi_cfg_index_t;

    typedef struct packed {
        logic                 start;
        logic [VALUE_W-1:0]   dividend;
        logic [DIVISOR_W-1:0] divisor;
    } thi_div_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
    } thi_div_rsp_t;

endpackage

### rtl/thi_in_if.sv
// Input channel of the block: one closing price per item.
// Depends on thi_pkg.
interface thi_in_if import thi_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] close_price;

    modport source (output valid, output close_price, input ready);
    modport sink (input valid, input close_price, output ready);
endinterface

### rtl/thi_out_if.sv
// Output channel of the block: triple EMA, Hull average and their compare flag.
// Depends on thi_pkg.
interface thi_out_if import thi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      indicators_valid;
    logic signed [VALUE_W-1:0] tema_value;
    logic signed [VALUE_W-1:0] hull_value;
    logic                      hull_not_above_tema;

    modport source (output valid, output indicators_valid, output tema_value,
                    output hull_value, output hull_not_above_tema, input ready);
    modport sink (input valid, input indicators_valid, input tema_value,
                  input hull_value, input hull_not_above_tema, output ready);
endinterface

### rtl/thi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on thi_pkg for the request and response types.
module thi_div import thi_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  thi_div_req_t req,
    output thi_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [VALUE_W-1:0]   quo_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DIVISOR_W:0]   rem_shift;
    logic [DIVISOR_W:0]   rem_diff;
    logic                 fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[VALUE_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        fits      = rem_shift >= {1'b0, divisor_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg    <= 1'b1;
                cnt_reg     <= '0;
                quo_reg     <= req.dividend;
                rem_reg     <= '0;
                divisor_reg <= req.divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[VALUE_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### rtl/tema_hull_indicator.sv
// Top level: three cascaded EMA stages with mean seeding, a price history
// memory and a Hull average, all worked through one shared multiplier.
// Depends on thi_pkg, thi_in_if, thi_out_if and thi_div.
// Items are handled one at a time: ready only when idle, so a new item is
// taken only after the last has passed the EMA stages, the history tap loop
// and the serial divider (the last two only when a Hull output is due) and
// has been moved into a free output register.
// Reset restores the register defaults and clears counters and averages;
// the history memory is not cleared and is read only where already written.
module tema_hull_indicator import thi_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    thi_in_if.sink            prices,
    thi_out_if.source         results,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_MUL_LO, S_MUL_HI, S_APPLY, S_TEMA,
        S_HADDR, S_HMULT, S_HACC, S_WDIV, S_WDIV_WAIT,
        S_HDIFF, S_HIMUL, S_HIADD, S_FDIV, S_FDIV_WAIT, S_DONE
    } state_t;

    state_t state_reg;

    logic [6:0]  tema_period_reg;
    logic [15:0] ema_weight_reg;
    logic [15:0] seed_recip_reg;
    logic [2:0]  hull_root_reg;

    logic [7:0]         count_reg;
    logic [HIST_AW-1:0] wp_reg;
    logic [HIST_AW-1:0] cur_wp_reg;
    logic [PRICE_W-1:0] x_reg;
    logic [1:0]         st_reg;
    logic               seed_reg;
    logic [VALUE_W-1:0] d_reg;
    logic [31:0]        p0_reg;
    logic signed [52:0] prod_reg;
    logic [VALUE_W-1:0] s1_reg, s2_reg, s3_reg;
    logic [VALUE_W-1:0] tema_reg, hull_reg;
    logic [2:0]         i_reg;
    logic               sel_reg;
    logic [5:0]         k_reg;
    logic [VALUE_W-1:0] sum_reg;
    logic [DIVISOR_W-1:0] tot_reg;
    logic [31:0]        wa_reg, wb_reg;
    logic signed [34:0] diff_reg;
    logic [VALUE_W-1:0] hacc_reg;
    logic [4:0]         htot_reg;
    logic               neg_reg;
    logic               ok_reg;

    logic                      out_valid_reg;
    logic                      out_ind_reg;
    logic signed [VALUE_W-1:0] out_tema_reg;
    logic signed [VALUE_W-1:0] out_hull_reg;
    logic                      out_flag_reg;

    logic [PRICE_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [PRICE_W-1:0] rd_data_reg;
    logic [HIST_AW-1:0] raddr;

    logic [6:0] p_eff;
    logic [2:0] r_eff;
    logic [5:0] h_len, half_len, n_len;
    logic [6:0] span;
    logic [8:0] thr_sel, c9;
    logic [VALUE_W-1:0] v_sel, a_sel, stage_new, tema_diff;
    logic [2:0] back;
    logic [6:0] off;
    logic seed_now, hull_ok;
    logic signed [35:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [52:0] mul_p;
    logic [15:0] weight;
    logic [VALUE_W-1:0] hacc_mag, fdiv_dividend;
    logic accept, out_free;
    thi_div_req_t div_req;
    thi_div_rsp_t div_rsp;

    thi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        if (tema_period_reg == 7'd0)
            p_eff = 7'd1;
        else if (tema_period_reg > 7'(MAX_PERIOD))
            p_eff = 7'(MAX_PERIOD);
        else
            p_eff = tema_period_reg;
        r_eff    = (hull_root_reg == 3'd0) ? 3'd1 : hull_root_reg;
        h_len    = 6'(r_eff * r_eff);
        half_len = (h_len[5:1] == 5'd0) ? 6'd1 : {1'b0, h_len[5:1]};
        span     = {1'b0, h_len} + {4'b0, r_eff} - 7'd1;
        c9       = {1'b0, count_reg};
        case (st_reg)
            2'd0:    thr_sel = {2'b0, p_eff};
            2'd1:    thr_sel = {1'b0, p_eff, 1'b0};
            default: thr_sel = {2'b0, p_eff} + {1'b0, p_eff, 1'b0};
        endcase
        seed_now = c9 < thr_sel;
        case (st_reg)
            2'd0:
            begin
                v_sel = {16'b0, x_reg};
                a_sel = s1_reg;
            end
            2'd1:
            begin
                v_sel = s1_reg;
                a_sel = s2_reg;
            end
            default:
            begin
                v_sel = s2_reg;
                a_sel = s3_reg;
            end
        endcase
        stage_new = a_sel + prod_reg[VALUE_W-1:0] + {32'b0, p0_reg[31:16]};
        tema_diff = s1_reg - s2_reg;
        hull_ok   = (span <= 7'(HISTORY_DEPTH)) && ((c9 + 9'd1) >= {2'b0, span});
        n_len     = sel_reg ? h_len : half_len;
        back      = r_eff - i_reg;
        off       = {4'b0, back} + {1'b0, n_len} - {1'b0, k_reg};
        raddr     = cur_wp_reg - off[HIST_AW-1:0];
        weight    = seed_reg ? seed_recip_reg : ema_weight_reg;
        hacc_mag  = hacc_reg[VALUE_W-1] ? (VALUE_W'(0) - hacc_reg) : hacc_reg;
        fdiv_dividend = hacc_reg[VALUE_W-1]
                        ? hacc_mag + {43'b0, htot_reg} - VALUE_W'(1) : hacc_mag;
    end

    always_comb
    begin
        case (state_reg)
            S_MUL_LO:
            begin
                mul_a = {20'b0, d_reg[15:0]};
                mul_b = {1'b0, weight};
            end
            S_MUL_HI:
            begin
                mul_a = {{4{d_reg[VALUE_W-1]}}, d_reg[VALUE_W-1:16]};
                mul_b = {1'b0, weight};
            end
            S_HMULT:
            begin
                mul_a = {4'b0, rd_data_reg};
                mul_b = {11'b0, k_reg};
            end
            default:
            begin
                mul_a = {diff_reg[34], diff_reg};
                mul_b = {14'b0, i_reg};
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        div_req.start    = (state_reg == S_WDIV) || (state_reg == S_FDIV);
        div_req.dividend = (state_reg == S_FDIV) ? fdiv_dividend : sum_reg;
        div_req.divisor  = (state_reg == S_FDIV) ? {6'b0, htot_reg} : tot_reg;
    end

    assign accept   = prices.valid && prices.ready;
    assign out_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
            hist_mem[wp_reg] <= prices.close_price;
        rd_data_reg <= hist_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tema_period_reg <= 7'd9;
            ema_weight_reg  <= 16'd13107;
            seed_recip_reg  <= 16'd7282;
            hull_root_reg   <= 3'd4;
        end
        else if (cfg_we)
        begin
            unique case (thi_cfg_index_t'(cfg_index))
                CFG_TEMA_PERIOD:     tema_period_reg <= cfg_data[6:0];
                CFG_EMA_WEIGHT:      ema_weight_reg  <= cfg_data;
                CFG_SEED_RECIPROCAL: seed_recip_reg  <= cfg_data;
                CFG_HULL_ROOT:       hull_root_reg   <= cfg_data[2:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wp_reg        <= '0;
            cur_wp_reg    <= '0;
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            st_reg        <= '0;
            seed_reg      <= 1'b0;
            x_reg         <= '0;
            d_reg         <= '0;
            p0_reg        <= '0;
            prod_reg      <= '0;
            tema_reg      <= '0;
            hull_reg      <= '0;
            i_reg         <= '0;
            sel_reg       <= 1'b0;
            k_reg         <= '0;
            sum_reg       <= '0;
            tot_reg       <= '0;
            wa_reg        <= '0;
            wb_reg        <= '0;
            diff_reg      <= '0;
            hacc_reg      <= '0;
            htot_reg      <= '0;
            neg_reg       <= 1'b0;
            out_ind_reg   <= 1'b0;
            out_tema_reg  <= '0;
            out_hull_reg  <= '0;
            out_flag_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && results.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg      <= prices.close_price;
                        cur_wp_reg <= wp_reg;
                        wp_reg     <= wp_reg + 1'b1;
                        st_reg     <= 2'd0;
                        ok_reg     <= 1'b0;
                        state_reg  <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    seed_reg  <= seed_now;
                    d_reg     <= seed_now ? v_sel : v_sel - a_sel;
                    state_reg <= S_MUL_LO;
                end
                S_MUL_LO:
                begin
                    p0_reg    <= mul_p[31:0];
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    case (st_reg)
                        2'd0:    s1_reg <= stage_new;
                        2'd1:    s2_reg <= stage_new;
                        default: s3_reg <= stage_new;
                    endcase
                    if (seed_reg)
                        state_reg <= S_DONE;
                    else if (st_reg == 2'd2)
                        state_reg <= S_TEMA;
                    else
                    begin
                        st_reg    <= st_reg + 1'b1;
                        state_reg <= S_PREP;
                    end
                end
                S_TEMA:
                begin
                    tema_reg <= tema_diff + {tema_diff[VALUE_W-2:0], 1'b0} + s3_reg;
                    i_reg    <= 3'd1;
                    sel_reg  <= 1'b0;
                    k_reg    <= 6'd1;
                    sum_reg  <= '0;
                    tot_reg  <= '0;
                    hacc_reg <= '0;
                    htot_reg <= '0;
                    state_reg <= hull_ok ? S_HADDR : S_DONE;
                end
                S_HADDR:
                begin
                    state_reg <= S_HMULT;
                end
                S_HMULT:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_HACC;
                end
                S_HACC:
                begin
                    sum_reg <= sum_reg + prod_reg[VALUE_W-1:0];
                    tot_reg <= tot_reg + {5'b0, k_reg};
                    if (k_reg == n_len)
                        state_reg <= S_WDIV;
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_HADDR;
                    end
                end
                S_WDIV:
                begin
                    state_reg <= S_WDIV_WAIT;
                end
                S_WDIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        if (!sel_reg)
                        begin
                            wa_reg    <= div_rsp.quotient[31:0];
                            sel_reg   <= 1'b1;
                            k_reg     <= 6'd1;
                            sum_reg   <= '0;
                            tot_reg   <= '0;
                            state_reg <= S_HADDR;
                        end
                        else
                        begin
                            wb_reg    <= div_rsp.quotient[31:0];
                            state_reg <= S_HDIFF;
                        end
                    end
                end
                S_HDIFF:
                begin
                    diff_reg  <= $signed({2'b0, wa_reg, 1'b0}) - $signed({3'b0, wb_reg});
                    state_reg <= S_HIMUL;
                end
                S_HIMUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_HIADD;
                end
                S_HIADD:
                begin
                    hacc_reg <= hacc_reg + prod_reg[VALUE_W-1:0];
                    htot_reg <= htot_reg + {2'b0, i_reg};
                    if (i_reg == r_eff)
                        state_reg <= S_FDIV;
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        sel_reg   <= 1'b0;
                        k_reg     <= 6'd1;
                        sum_reg   <= '0;
                        tot_reg   <= '0;
                        state_reg <= S_HADDR;
                    end
                end
                S_FDIV:
                begin
                    neg_reg   <= hacc_reg[VALUE_W-1];
                    state_reg <= S_FDIV_WAIT;
                end
                S_FDIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        hull_reg  <= neg_reg ? VALUE_W'(0) - div_rsp.quotient
                                             : div_rsp.quotient;
                        ok_reg    <= 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ind_reg   <= ok_reg;
                        out_tema_reg  <= ok_reg ? tema_reg : '0;
                        out_hull_reg  <= ok_reg ? hull_reg : '0;
                        out_flag_reg  <= ok_reg && ($signed(hull_reg) <= $signed(tema_reg));
                        if (count_reg != 8'hFF)
                            count_reg <= count_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign prices.ready                = (state_reg == S_IDLE);
    assign results.valid               = out_valid_reg;
    assign results.indicators_valid    = out_ind_reg;
    assign results.tema_value          = out_tema_reg;
    assign results.hull_value          = out_hull_reg;
    assign results.hull_not_above_tema = out_flag_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_WDIV_WAIT || state_reg == S_FDIV_WAIT))
        else $error("divider finished outside a wait state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !prices.ready)
        else $error("block ready right after taking an item");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.indicators_valid) |->
        (results.tema_value == '0 && results.hull_value == '0 &&
         !results.hull_not_above_tema))
        else $error("undefined result carries nonzero fields");

endmodule

### sim/tb_tema_hull_indicator.sv
// Testbench for tema_hull_indicator: random and directed price items, with checks
// against a built-in triple EMA and Hull average predictor at every result item.
// Depends on thi_pkg, thi_in_if, thi_out_if and the block's RTL.
module tb_tema_hull_indicator;
    import thi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 12_000_000;
    localparam int DRAIN_PAUSE = 12;
    localparam int LONG_HOLD = 4000;

    typedef struct {
        bit                 ok;
        logic signed [47:0] tema;
        logic signed [47:0] hull;
        bit                 not_above;
    } indicators_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_AW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    thi_in_if prices_ch ();
    thi_out_if results_ch ();

    tema_hull_indicator dut (
        .clk(clk), .rst_n(rst_n), .prices(prices_ch), .results(results_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bit [6:0] period_reg;
    bit [15:0] weight_reg;
    bit [15:0] recip_reg;
    bit [2:0] root_reg;
    int unsigned samples_seen;
    longint stage1, stage2, stage3;
    bit [31:0] history [HISTORY_DEPTH];
    int unsigned hist_wp;

    indicators_t expected_q[$];
    int mismatches = 0;
    int items_sent = 0;
    int results_checked = 0;
    int valid_results = 0;
    int reg_writes = 0;
    int burst_left = 0;
    bit hold_request = 0;
    longint cycles = 0;
    bit [31:0] last_price = 32'h0064_0000;

    always #10 clk = ~clk;

    function automatic longint sext48(longint v);
        longint s;
        s = v <<< 16;
        return s >>> 16;
    endfunction

    function automatic longint scale_q16(longint d, longint w);
        longint hi;
        longint lo;
        hi = d >>> 16;
        lo = d & 64'hFFFF;
        return hi * w + ((lo * w) >>> 16);
    endfunction

    function automatic longint smooth(longint a, longint v);
        return sext48(a + scale_q16(sext48(v - a), longint'(weight_reg)));
    endfunction

    function automatic longint weighted_mean(int unsigned back, int unsigned n);
        longint sum;
        longint tot;
        int unsigned idx;
        sum = 0;
        tot = 0;
        for (int unsigned k = 1; k <= n; k++)
        begin
            idx = (hist_wp + HISTORY_DEPTH - ((back + n - k) % HISTORY_DEPTH)) % HISTORY_DEPTH;
            sum += longint'(k) * longint'({32'b0, history[idx]});
            tot += k;
        end
        return sum / tot;
    endfunction

    function automatic indicators_t predict_indicators(bit [31:0] x);
        indicators_t res;
        int unsigned p;
        int unsigned r;
        int unsigned h;
        int unsigned half;
        int unsigned span;
        int unsigned c;
        bit have_tema;
        longint tema;
        longint hull;
        longint acc;
        longint tot;
        p = period_reg;
        r = root_reg;
        c = samples_seen;
        have_tema = 0;
        tema = 0;
        hull = 0;
        if (p < 1) p = 1;
        if (p > MAX_PERIOD) p = MAX_PERIOD;
        if (r < 1) r = 1;
        h = r * r;
        half = h / 2;
        if (half < 1) half = 1;
        span = h + r - 1;
        history[hist_wp] = x;
        if (c < p)
        begin
            stage1 = sext48(stage1 + scale_q16(longint'({32'b0, x}), longint'(recip_reg)));
        end
        else
        begin
            stage1 = smooth(stage1, longint'({32'b0, x}));
            if (c < 2 * p)
            begin
                stage2 = sext48(stage2 + scale_q16(stage1, longint'(recip_reg)));
            end
            else
            begin
                stage2 = smooth(stage2, stage1);
                if (c < 3 * p)
                begin
                    stage3 = sext48(stage3 + scale_q16(stage2, longint'(recip_reg)));
                end
                else
                begin
                    stage3 = smooth(stage3, stage2);
                    tema = sext48(3 * (stage1 - stage2) + stage3);
                    have_tema = 1;
                end
            end
        end
        res.ok = have_tema && span <= HISTORY_DEPTH && c + 1 >= span;
        if (res.ok)
        begin
            acc = 0;
            tot = 0;
            for (int unsigned i = 1; i <= r; i++)
            begin
                acc += longint'(i) * (2 * weighted_mean(r - i, half) - weighted_mean(r - i, h));
                tot += i;
            end
            if (acc >= 0) hull = sext48(acc / tot);
            else hull = sext48(-((-acc + tot - 1) / tot));
        end
        if (samples_seen < 255) samples_seen++;
        hist_wp = (hist_wp + 1) % HISTORY_DEPTH;
        res.tema = res.ok ? tema[47:0] : '0;
        res.hull = res.ok ? hull[47:0] : '0;
        res.not_above = res.ok && hull <= tema;
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        mismatches++;
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 field, results_checked, got, want);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL tema_hull_indicator");
            $finish;
        end
    end

    // The receiver cycles through free-running, random and periodic stall modes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_ch.ready <= 0;
        end
        else
        begin
            case ((cycles >> 8) % 4)
                0: results_ch.ready <= !hold_request;
                1: results_ch.ready <= !hold_request && ($urandom_range(0, 1) == 1);
                2: results_ch.ready <= !hold_request && (cycles[1:0] != 2'b00);
                default: results_ch.ready <= !hold_request && ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        indicators_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected item", 1, 0);
            end
            else
            begin
                want = expected_q.pop_front();
                if (results_ch.indicators_valid !== want.ok)
                    report_mismatch("indicators_valid", results_ch.indicators_valid, want.ok);
                if (results_ch.tema_value !== want.tema)
                    report_mismatch("tema_value", results_ch.tema_value, want.tema);
                if (results_ch.hull_value !== want.hull)
                    report_mismatch("hull_value", results_ch.hull_value, want.hull);
                if (results_ch.hull_not_above_tema !== want.not_above)
                    report_mismatch("hull_not_above_tema", results_ch.hull_not_above_tema,
                                    want.not_above);
                if (want.ok) valid_results++;
            end
            results_checked++;
        end
    end

    initial
    begin
        forever
        begin
            wait (hold_request);
            repeat (LONG_HOLD) @(posedge clk);
            hold_request = 0;
        end
    end

    task automatic write_reg(thi_cfg_index_t idx, bit [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        case (idx)
            CFG_TEMA_PERIOD: period_reg = val[6:0];
            CFG_EMA_WEIGHT: weight_reg = val;
            CFG_SEED_RECIPROCAL: recip_reg = val;
            CFG_HULL_ROOT: root_reg = val[2:0];
        endcase
        reg_writes++;
    endtask

    task automatic configure(bit [15:0] p, bit [15:0] w, bit [15:0] s, bit [15:0] r);
        write_reg(CFG_TEMA_PERIOD, p);
        write_reg(CFG_EMA_WEIGHT, w);
        write_reg(CFG_SEED_RECIPROCAL, s);
        write_reg(CFG_HULL_ROOT, r);
    endtask

    task automatic send_price(bit [31:0] x);
        if (burst_left == 0)
        begin
            prices_ch.valid <= 0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 12);
        end
        prices_ch.valid <= 1;
        prices_ch.close_price <= x;
        do @(posedge clk); while (!prices_ch.ready);
        expected_q.push_back(predict_indicators(x));
        items_sent++;
        burst_left--;
        last_price = x;
    endtask

    task automatic wait_idle();
        prices_ch.valid <= 0;
        burst_left = 0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    function automatic bit [31:0] next_price();
        bit [31:0] step;
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            default:
            begin
                step = $urandom_range(0, 32'h0008_0000);
                if ($urandom_range(0, 1) == 1) return last_price + step;
                return last_price - step;
            end
        endcase
    endfunction

    task automatic test_short_periods();
        bit [31:0] edge_prices [10];
        edge_prices = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
                        32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0};
        // Period zero and hull root zero act as one; bits above the fields are ignored.
        configure(16'hFF80, 16'hFFFF, 16'hFFFF, 16'hFFF8);
        foreach (edge_prices[i])
            send_price(edge_prices[i]);
        wait_idle();
        configure(16'd1, 16'd1, 16'd1, 16'd1);
        for (int i = 0; i < 6; i++) send_price(i[0] ? 32'hFFFF_FFFF : 32'h0);
        wait_idle();
        configure(16'd127, 16'd40000, 16'd1024, 16'd2);
        for (int i = 0; i < 6; i++) send_price($urandom);
        wait_idle();
    endtask

    task automatic test_random_settings(int phases, int per_phase);
        bit [15:0] p;
        bit [15:0] w;
        bit [15:0] s;
        bit [15:0] r;
        for (int ph = 0; ph < phases; ph++)
        begin
            case ($urandom_range(0, 9))
                0: p = {9'($urandom_range(0, 511)), 7'd0};
                1: p = {9'($urandom_range(0, 511)), 7'd127};
                2: p = 16'd64;
                default: p = 16'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 5))
                0: w = 16'd1;
                1: w = 16'hFFFF;
                default: w = 16'($urandom_range(1, 65535));
            endcase
            s = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
            r = (ph == phases - 1 || $urandom_range(0, 9) == 0)
                ? 16'd7 : 16'($urandom_range(0, 3));
            configure(p, w, s, r);
            for (int i = 0; i < per_phase; i++) send_price(next_price());
            wait_idle();
        end
    endtask

    task automatic test_long_stall(int count);
        configure(16'd3, 16'd32768, 16'd21845, 16'd2);
        hold_request = 1;
        for (int i = 0; i < count; i++) send_price(next_price());
        wait_idle();
    endtask

    initial
    begin
        prices_ch.valid = 0;
        prices_ch.close_price = '0;
        period_reg = 7'd9;
        weight_reg = 16'd13107;
        recip_reg = 16'd7282;
        root_reg = 3'd4;
        samples_seen = 0;
        stage1 = 0;
        stage2 = 0;
        stage3 = 0;
        hist_wp = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int i = 0; i < 4; i++) send_price(next_price());
        wait_idle();
        test_short_periods();
        test_random_settings(5, 51);
        test_long_stall(40);
        test_random_settings(5, 51);
        repeat (50) @(posedge clk);
        $display("Covered %0d price items and %0d results (%0d with indicators defined),",
                 items_sent, results_checked, valid_results);
        $display("with %0d register writes across period, weight and hull root extremes.",
                 reg_writes);
        if (mismatches == 0 && expected_q.size() == 0)
        begin
            $display("PASS tema_hull_indicator");
        end
        else
        begin
            $display("FAIL tema_hull_indicator");
        end
        $finish;
    end
endmodule

### sim.f
rtl/thi_pkg.sv
rtl/thi_in_if.sv
rtl/thi_out_if.sv
rtl/thi_div.sv
rtl/tema_hull_indicator.sv
sim/tb_tema_hull_indicator.sv
